FILE: hw/rtl/cfws_pkg.sv
// Shared types and constants for the circular FIFO with search.
// No dependencies; used by cfws_ctrl, cfws_dp and circular_fifo_with_search.
package cfws_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int WORD_W        = 32;
    localparam int S_TDATA_W     = 40;   // action(2) + value(32), padded to bytes
    localparam int M_TDATA_W     = 40;   // status(2) + data(32) + found(1), padded

    typedef enum logic [1:0] {
        ACT_ENQ    = 2'd0,
        ACT_DEQ    = 2'd1,
        ACT_PEEK   = 2'd2,
        ACT_SEARCH = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCAN,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic latch_in;    // capture request, clear result
        logic enq_write;   // write word at tail, advance tail, count up
        logic mem_read;    // read slot at head (or next scan slot with scan_next)
        logic scan_start;  // scan pointer <= head, remaining <= count
        logic scan_next;   // advance scan pointer, remaining down
        logic deq_pop;     // advance head, count down
        logic res_full;
        logic res_empty;
        logic res_data;    // result data <= read data
        logic res_found;
        logic load_out;    // result -> output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        action_t action;
        logic    full;
        logic    empty;
        logic    match;    // read data equals search value
        logic    last;     // current scan slot is the newest entry
    } sts_t;

endpackage

FILE: hw/rtl/cfws_ctrl.sv
// Controller FSM for the circular FIFO with search.
// Depends on cfws_pkg; drives cfws_dp through cmd_t, observes sts_t.
module cfws_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  cfws_pkg::sts_t sts,
    output cfws_pkg::cmd_t cmd
);

    cfws_pkg::state_t state_reg, state_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == cfws_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cfws_pkg::S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            cfws_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = cfws_pkg::S_EXEC;
                end
            end
            cfws_pkg::S_EXEC: begin
                case (sts.action)
                    cfws_pkg::ACT_ENQ: begin
                        if (sts.full) cmd.res_full = 1'b1;
                        else          cmd.enq_write = 1'b1;
                        state_next = cfws_pkg::S_DONE;
                    end
                    cfws_pkg::ACT_DEQ, cfws_pkg::ACT_PEEK: begin
                        if (sts.empty) begin
                            cmd.res_empty = 1'b1;
                            state_next    = cfws_pkg::S_DONE;
                        end else begin
                            cmd.mem_read = 1'b1;
                            state_next   = cfws_pkg::S_READ;
                        end
                    end
                    cfws_pkg::ACT_SEARCH: begin
                        if (sts.empty) begin
                            state_next = cfws_pkg::S_DONE;
                        end else begin
                            cmd.mem_read   = 1'b1;
                            cmd.scan_start = 1'b1;
                            state_next     = cfws_pkg::S_SCAN;
                        end
                    end
                    default: state_next = cfws_pkg::S_DONE;
                endcase
            end
            cfws_pkg::S_READ: begin
                cmd.res_data = 1'b1;
                cmd.deq_pop  = (sts.action == cfws_pkg::ACT_DEQ);
                state_next   = cfws_pkg::S_DONE;
            end
            cfws_pkg::S_SCAN: begin
                if (sts.match) begin
                    cmd.res_found = 1'b1;
                    state_next    = cfws_pkg::S_DONE;
                end else if (sts.last) begin
                    state_next = cfws_pkg::S_DONE;
                end else begin
                    cmd.mem_read  = 1'b1;
                    cmd.scan_next = 1'b1;
                end
            end
            cfws_pkg::S_DONE: begin
                if (out_free) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = cfws_pkg::S_IDLE;
                end
            end
            default: state_next = cfws_pkg::S_IDLE;
        endcase
    end

endmodule

FILE: hw/rtl/cfws_dp.sv
// Datapath for the circular FIFO with search: ring memory, pointers, result.
// Depends on cfws_pkg; commanded by cfws_ctrl.
module cfws_dp #(
    parameter int DEPTH = cfws_pkg::DEFAULT_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [1:0]                     in_action,
    input  logic signed [cfws_pkg::WORD_W-1:0] in_value,
    input  cfws_pkg::cmd_t                 cmd,
    output cfws_pkg::sts_t                 sts,
    output logic [1:0]                     out_status,
    output logic signed [cfws_pkg::WORD_W-1:0] out_data,
    output logic                           out_found
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] slot);
        return (slot == LAST_SLOT) ? '0 : slot + 1'b1;
    endfunction

    logic [cfws_pkg::WORD_W-1:0] mem [DEPTH];

    logic [AW-1:0]  head_reg, tail_reg, scan_reg;
    logic [CW-1:0]  count_reg, remain_reg;
    cfws_pkg::action_t action_reg;
    logic [cfws_pkg::WORD_W-1:0] value_reg, rd_data_reg;
    cfws_pkg::status_t res_status_reg;
    logic [cfws_pkg::WORD_W-1:0] res_data_reg;
    logic           res_found_reg;
    logic [1:0]     out_status_reg;
    logic [cfws_pkg::WORD_W-1:0] out_data_reg;
    logic           out_found_reg;
    logic [AW-1:0]  rd_addr;

    assign rd_addr = cmd.scan_next ? next_slot(scan_reg) : head_reg;

    // ring memory, one write or one read per cycle, registered read
    always_ff @(posedge aclk) begin
        if (cmd.enq_write) mem[tail_reg] <= value_reg;
        if (cmd.mem_read)  rd_data_reg   <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.enq_write) begin
                tail_reg  <= next_slot(tail_reg);
                count_reg <= count_reg + 1'b1;
            end else if (cmd.deq_pop) begin
                head_reg  <= next_slot(head_reg);
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            action_reg     <= cfws_pkg::action_t'(in_action);
            value_reg      <= in_value;
            res_status_reg <= cfws_pkg::STS_OK;
            res_data_reg   <= '0;
            res_found_reg  <= 1'b0;
        end
        if (cmd.scan_start) begin
            scan_reg   <= head_reg;
            remain_reg <= count_reg;
        end else if (cmd.scan_next) begin
            scan_reg   <= next_slot(scan_reg);
            remain_reg <= remain_reg - 1'b1;
        end
        if (cmd.res_full)  res_status_reg <= cfws_pkg::STS_FULL;
        if (cmd.res_empty) res_status_reg <= cfws_pkg::STS_EMPTY;
        if (cmd.res_data)  res_data_reg   <= rd_data_reg;
        if (cmd.res_found) res_found_reg  <= 1'b1;
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_data_reg   <= res_data_reg;
            out_found_reg  <= res_found_reg;
        end
    end

    assign sts.action = action_reg;
    assign sts.full   = (count_reg == FULL_CNT);
    assign sts.empty  = (count_reg == '0);
    assign sts.match  = (rd_data_reg == value_reg);
    assign sts.last   = (remain_reg == CW'(1));

    assign out_status = out_status_reg;
    assign out_data   = out_data_reg;
    assign out_found  = out_found_reg;

endmodule

FILE: hw/rtl/circular_fifo_with_search.sv
// Each request passes S_IDLE, S_EXEC and S_DONE; a dequeue/peek on a non-empty queue
// adds S_READ, and a search adds S_SCAN, comparing the entries from oldest to newest
// (1..DEPTH of them; none if empty). S_DONE waits until the output register is free.
// A new request is accepted only back in S_IDLE, after the previous result is loaded;
// the search walks the ring one entry per cycle through the single memory read port.
// Reset (aresetn, synchronous, active low) empties the queue and drops any result;
// memory contents are not cleared, since only live entries are ever read.
module circular_fifo_with_search #(
    parameter int DEPTH = cfws_pkg::DEFAULT_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cfws_pkg::S_TDATA_W-1:0]   s_tdata,  // [1:0] action, [33:2] value
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cfws_pkg::M_TDATA_W-1:0]   m_tdata   // [1:0] status, [33:2] data,
                                                       // [34] found
);

    cfws_pkg::cmd_t cmd;
    cfws_pkg::sts_t sts;

    logic [1:0]                         out_status;
    logic signed [cfws_pkg::WORD_W-1:0] out_data;
    logic                               out_found;

    // FSM: sequences each request, owns both handshakes
    cfws_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // ring memory, head/tail/count, scan pointer, result and output registers
    cfws_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_action  (s_tdata[1:0]),
        .in_value   (s_tdata[33:2]),
        .cmd        (cmd),
        .sts        (sts),
        .out_status (out_status),
        .out_data   (out_data),
        .out_found  (out_found)
    );

    assign m_tdata = {5'b0, out_found, out_data, out_status};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // queue can never look full and empty at once
    a_full_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sts.full && sts.empty))
        else $error("queue reports full and empty together");

    // one request in flight: ready drops right after an accepted transaction
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in progress");

    // a found flag only accompanies an ok status
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[34]) |-> (m_tdata[1:0] == cfws_pkg::STS_OK))
        else $error("found set on an error result");

    // error results carry zero data
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] != cfws_pkg::STS_OK)) |-> (m_tdata[33:2] == '0))
        else $error("error result with nonzero data");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for circular_fifo_with_search: a random and directed request
// stream with a cycle-free predictor of the ring buffer and a scoreboard of results.
// Depends on cfws_pkg and the circular_fifo_with_search RTL.
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH      = cfws_pkg::DEFAULT_DEPTH;
    localparam int N_ITEMS    = 1900;
    localparam int HALF_CLK   = 6;
    localparam int RST_CYCLES = 10;
    localparam int IDLE_PCT   = 29;
    localparam int HOLD_LEN   = 150;     // long receiver hold-off, in cycles
    localparam int TAIL_WAIT  = 2 * (DEPTH + 4);
    localparam int STALL_MAX  = 2000;    // cycles without any transaction before giving up

    // one pending request; 'pause' makes the driver wait for an empty scoreboard first
    typedef struct {
        cfws_pkg::action_t act;
        logic [31:0]       word;
        bit                pause;
    } fifo_req_t;

    typedef struct {
        cfws_pkg::status_t sts;
        logic [31:0]       data;
        logic              found;
    } fifo_result_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [cfws_pkg::S_TDATA_W-1:0] s_tdata  = '0;   // [1:0] action, [33:2] value
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [cfws_pkg::M_TDATA_W-1:0] m_tdata;   // [1:0] status, [33:2] data, [34] found

    fifo_req_t    req_q[$];        // requests not yet offered
    fifo_result_t result_q[$];     // results owed by the block, oldest first
    logic [31:0]  shadow_q[$];     // stimulus-side view of contents, used to aim searches
    bit           pause_pending;

    // predictor state
    logic [31:0] ring_mem [DEPTH];
    int          ring_head, ring_tail, ring_cnt;

    bit req_taken;                 // previous rising edge moved a request transaction
    int err_cnt, results_cnt, cycle_cnt, stall_cnt;
    int hold_left, next_hold_at;
    int n_act [4];
    int n_full, n_empty, n_found, peak_fill;

    circular_fifo_with_search #(.DEPTH(DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #HALF_CLK aclk = 1'b1;
        #HALF_CLK aclk = 1'b0;
    end

    // No idling at all inside this window of the run.
    function automatic bit may_idle();
        if (cycle_cnt >= 4000 && cycle_cnt < 7000) return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // Biased word source: extremes, a small set that makes duplicates, and full-range noise.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            4, 5:    return 32'($urandom_range(0, 7));
            default: return $urandom();
        endcase
    endfunction

    // Search value: mostly something stored (any position, newest included), else random.
    function automatic logic [31:0] pick_target();
        if (shadow_q.size() != 0 && $urandom_range(0, 2) != 0)
            return shadow_q[$urandom_range(0, shadow_q.size() - 1)];
        return pick_word();
    endfunction

    task automatic add_req(input cfws_pkg::action_t act, input logic [31:0] word);
        fifo_req_t r;
        r.act   = act;
        r.word  = word;
        r.pause = pause_pending;
        pause_pending = 1'b0;
        req_q.push_back(r);
        case (act)
            cfws_pkg::ACT_ENQ: if (shadow_q.size() < DEPTH) shadow_q.push_back(word);
            cfws_pkg::ACT_DEQ: if (shadow_q.size() != 0) void'(shadow_q.pop_front());
            default: ;
        endcase
    endtask

    // Expected result of one request; advances the predictor state.
    task automatic fifo_predict(input cfws_pkg::action_t act, input logic [31:0] word,
                                output fifo_result_t res);
        int slot;
        res.sts   = cfws_pkg::STS_OK;
        res.data  = '0;
        res.found = 1'b0;
        case (act)
            cfws_pkg::ACT_ENQ: begin
                if (ring_cnt == DEPTH) begin
                    res.sts = cfws_pkg::STS_FULL;  // word dropped, nothing moves
                end else begin
                    ring_mem[ring_tail] = word;
                    ring_tail = (ring_tail + 1) % DEPTH;
                    ring_cnt++;
                end
            end
            cfws_pkg::ACT_DEQ, cfws_pkg::ACT_PEEK: begin
                if (ring_cnt == 0) begin
                    res.sts = cfws_pkg::STS_EMPTY;
                end else begin
                    res.data = ring_mem[ring_head];
                    if (act == cfws_pkg::ACT_DEQ) begin
                        ring_head = (ring_head + 1) % DEPTH;
                        ring_cnt--;
                    end
                end
            end
            default: begin
                // oldest to newest over live entries only
                slot = ring_head;
                for (int k = 0; k < ring_cnt; k++) begin
                    if (ring_mem[slot] == word) res.found = 1'b1;
                    slot = (slot + 1) % DEPTH;
                end
            end
        endcase
    endtask

    // Driver: offers requests at the falling edge, holds a request until it is taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_taken) begin
            if (req_q.size() != 0 && !(req_q[0].pause && result_q.size() != 0)
                    && !may_idle()) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {6'b0, req_q[0].word, req_q[0].act};
                void'(req_q.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: random back-pressure plus a long hold-off at two points of the run.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (results_cnt >= next_hold_at) begin
            hold_left    = HOLD_LEN - 1;
            next_hold_at = next_hold_at + 800;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !may_idle();
        end
    end

    // Monitor: predicts each accepted request, then checks any result of this edge.
    always @(posedge aclk) begin
        fifo_result_t res, want;
        logic         got_found;
        logic [1:0]   got_sts;
        logic [31:0]  got_data;
        if (aresetn) begin
            cycle_cnt++;
            req_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                fifo_predict(cfws_pkg::action_t'(s_tdata[1:0]), s_tdata[33:2], res);
                result_q.push_back(res);
                n_act[s_tdata[1:0]]++;
                if (res.sts == cfws_pkg::STS_FULL)  n_full++;
                if (res.sts == cfws_pkg::STS_EMPTY) n_empty++;
                if (res.found)                      n_found++;
                if (ring_cnt > peak_fill) peak_fill = ring_cnt;
            end
            if (m_tvalid && m_tready) begin
                results_cnt++;
                got_sts   = m_tdata[1:0];
                got_data  = m_tdata[33:2];
                got_found = m_tdata[34];
                if (result_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result transaction, tdata=%h", $time, m_tdata);
                end else begin
                    want = result_q.pop_front();
                    if (got_sts !== want.sts) begin
                        err_cnt++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.sts, got_sts);
                    end
                    if (got_data !== want.data) begin
                        err_cnt++;
                        $display("%0t: data mismatch, expected %h, got %h",
                                 $time, want.data, got_data);
                    end
                    if (got_found !== want.found) begin
                        err_cnt++;
                        $display("%0t: found mismatch, expected %b, got %b",
                                 $time, want.found, got_found);
                    end
                end
            end
            // watchdog: nothing moving on either channel for too long
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_MAX) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, STALL_MAX, result_q.size());
                $display("circular_fifo_with_search regression: fail");
                $finish;
            end
        end
    end

    initial begin
        int n;
        int next_pause;
        ring_head    = 0;
        ring_tail    = 0;
        ring_cnt     = 0;
        next_hold_at = 500;
        next_pause   = 300;

        // Directed: empty-queue cases, extreme words, hit and miss, drain to empty.
        add_req(cfws_pkg::ACT_PEEK, 32'hFFFF_FFFF);
        add_req(cfws_pkg::ACT_DEQ, 32'h0000_0000);
        add_req(cfws_pkg::ACT_SEARCH, 32'h0000_0000);   // empty queue: not found
        add_req(cfws_pkg::ACT_ENQ, 32'h8000_0000);
        add_req(cfws_pkg::ACT_ENQ, 32'h7FFF_FFFF);
        add_req(cfws_pkg::ACT_ENQ, 32'h0000_0000);
        add_req(cfws_pkg::ACT_ENQ, 32'hFFFF_FFFF);
        add_req(cfws_pkg::ACT_SEARCH, 32'hFFFF_FFFF);   // newest entry
        add_req(cfws_pkg::ACT_SEARCH, 32'h8000_0000);   // oldest entry
        add_req(cfws_pkg::ACT_SEARCH, 32'h0000_0001);   // miss
        add_req(cfws_pkg::ACT_PEEK, 32'h5555_5555);
        repeat (4) add_req(cfws_pkg::ACT_DEQ, 32'hAAAA_AAAA);
        add_req(cfws_pkg::ACT_SEARCH, 32'h7FFF_FFFF);   // value gone; the dequeues drained the queue
        add_req(cfws_pkg::ACT_DEQ, 32'h0000_0000);      // empty again
        add_req(cfws_pkg::ACT_PEEK, 32'h0000_0000);

        // Random: fill and drain bursts so the queue hits full, wraps and empties often.
        while (req_q.size() < N_ITEMS) begin
            if (req_q.size() >= next_pause) begin
                pause_pending = 1'b1;
                next_pause    = next_pause + 450;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    n = $urandom_range(1, DEPTH + 3);
                    repeat (n) begin
                        add_req(cfws_pkg::ACT_ENQ, pick_word());
                        if ($urandom_range(0, 3) == 0)
                            add_req(cfws_pkg::ACT_SEARCH, pick_target());
                    end
                end
                3, 4: begin
                    n = $urandom_range(1, DEPTH + 2);
                    repeat (n) begin
                        if ($urandom_range(0, 4) == 0)
                            add_req(cfws_pkg::ACT_PEEK, pick_word());
                        add_req(cfws_pkg::ACT_DEQ, pick_word());
                    end
                end
                5, 6: begin
                    n = $urandom_range(1, 4);
                    repeat (n) add_req(cfws_pkg::ACT_SEARCH, pick_target());
                end
                default: add_req(cfws_pkg::action_t'($urandom_range(0, 3)), pick_word());
            endcase
        end

        repeat (RST_CYCLES) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        do @(posedge aclk); while (req_q.size() != 0 || s_tvalid || result_q.size() != 0);
        repeat (TAIL_WAIT) @(posedge aclk);

        $display("requests: %0d enqueue, %0d dequeue, %0d peek, %0d search",
                 n_act[cfws_pkg::ACT_ENQ], n_act[cfws_pkg::ACT_DEQ],
                 n_act[cfws_pkg::ACT_PEEK], n_act[cfws_pkg::ACT_SEARCH]);
        $display("%0d results checked; full refusals %0d, empty reports %0d, search hits %0d, peak fill %0d of %0d",
                 results_cnt, n_full, n_empty, n_found, peak_fill, DEPTH);
        if (err_cnt == 0)
            $display("circular_fifo_with_search regression: pass");
        else
            $display("circular_fifo_with_search regression: fail");
        $finish;
    end

endmodule
